// File: sv/oal_pkg.sv
package oal_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_DELETE = 2'd1;
  localparam mode_t MODE_LOCATE = 2'd2;
  localparam mode_t MODE_GET    = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic ins;
    logic del;
    logic loc;
  } cell_ctl_t;

endpackage

// File: sv/ordered_array_list.sv
// Positional list of up to DEPTH elements, packed from slot 1.
// Input beats (in_*) carry a request: insert, delete, locate or get.
// Every request yields exactly one output beat (out_*) with read value,
// found position, status, length and empty flag.
// The list lives in a row of slot cells; insert and delete shift the cells
// from the position up in the beat's accept cycle. Locate and get (and the
// value returned by delete) go through a registered binary select tree over
// the cells, log2(DEPTH) levels deep, in which the lowest hit wins.
// Only one request is in flight at a time:
// in_tready is low from accept until the result enters the output register.
// The output register holds the result while out_tready is low; a later
// request's result then waits in the tree until the register is taken, losing nothing.
// Reset empties the list at once (length 0); slot contents are not cleared
// since only slots below the length are ever read.
module ordered_array_list #(
  parameter int DEPTH      = 256,
  parameter int ELEM_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // mode[1:0], position, item_value, zero pad
  input  logic [((2 + $clog2(DEPTH + 1) + ELEM_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // read_value, found_position, status[1:0], length, is_empty, zero pad
  output logic [((ELEM_WIDTH + 2 * $clog2(DEPTH + 1) + 3 + 7) / 8) * 8 - 1:0] out_tdata
);
  import oal_pkg::*;

  localparam int EW    = ELEM_WIDTH;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int LVL   = IW;
  localparam int CNT_W = $clog2(LVL + 1);
  localparam int OUT_W = ((EW + 2 * PW + 3 + 7) / 8) * 8;

  mode_t         in_mode;
  logic [PW-1:0] in_pos;
  logic [EW-1:0] in_val;
  logic          in_acc;

  assign in_mode = in_tdata[1:0];
  assign in_pos  = in_tdata[2 +: PW];
  assign in_val  = in_tdata[2 + PW +: EW];
  assign in_acc  = in_tvalid && in_tready;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]    count_r, count_nxt;
  mode_t            rq_mode_r;
  status_t          rq_st_r;
  status_t          st_now;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [PW:0]   pos_x, count_x;
  logic [PW-1:0] pos_idx;
  cell_ctl_t     ctl;

  assign pos_x   = {1'b0, in_pos};
  assign count_x = {1'b0, count_r};
  assign pos_idx = in_pos - PW'(1);

  always_comb begin
    st_now = ST_DONE;
    case (in_mode)
      MODE_INSERT: begin
        if ((in_pos == '0) || (pos_x > count_x + (PW + 1)'(1))) begin
          st_now = ST_RANGE;
        end else if (count_r == PW'(DEPTH)) begin
          st_now = ST_FULL;
        end
      end
      MODE_DELETE, MODE_GET: begin
        if ((in_pos == '0) || (pos_x > count_x)) begin
          st_now = ST_RANGE;
        end
      end
      default: st_now = ST_DONE;
    endcase
  end

  always_comb begin
    ctl.ins = in_acc && (in_mode == MODE_INSERT) && (st_now == ST_DONE);
    ctl.del = in_acc && (in_mode == MODE_DELETE) && (st_now == ST_DONE);
    ctl.loc = (in_mode == MODE_LOCATE);
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + PW'(1);
    end else if (ctl.del) begin
      count_nxt = count_r - PW'(1);
    end
  end

  logic [EW-1:0]    slot_v [DEPTH];
  logic [DEPTH-1:0] leaf_hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] lv, rv;
    if (i == 0) begin : g_first
      assign lv = '0;
    end else begin : g_mid_l
      assign lv = slot_v[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = '0;
    end else begin : g_mid_r
      assign rv = slot_v[i+1];
    end
    oal_cell #(.IDX(i), .EW(EW), .PW(PW)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos_idx    (pos_idx),
      .count      (count_r),
      .item_value (in_val),
      .left_val   (lv),
      .right_val  (rv),
      .slot_val   (slot_v[i]),
      .leaf_hit   (leaf_hit[i])
    );
  end

  logic          root_hit;
  logic [IW-1:0] root_idx;
  logic [EW-1:0] root_val;

  oal_tree #(.DEPTH(DEPTH), .EW(EW)) u_tree (
    .clk      (clk),
    .load     (in_acc),
    .leaf_hit (leaf_hit),
    .leaf_val (slot_v),
    .root_hit (root_hit),
    .root_idx (root_idx),
    .root_val (root_val)
  );

  logic          fin;
  logic [EW-1:0] res_val;
  logic [PW-1:0] res_pos;

  assign fin = busy_r && (cnt_r == CNT_W'(LVL)) && (!out_tvalid_r || out_tready);

  always_comb begin
    res_val = '0;
    res_pos = '0;
    if ((rq_st_r == ST_DONE) && ((rq_mode_r == MODE_DELETE) || (rq_mode_r == MODE_GET))) begin
      res_val = root_val;
    end
    if ((rq_mode_r == MODE_LOCATE) && root_hit) begin
      res_pos = PW'(root_idx) + PW'(1);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (busy_r && (cnt_r != CNT_W'(LVL))) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      cnt_r        <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      count_r <= count_nxt;
      if (fin) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rq_mode_r <= in_mode;
      rq_st_r   <= st_now;
    end
    if (fin) begin
      out_data_r <= OUT_W'({(count_r == '0), count_r, rq_st_r, res_pos, res_val});
    end
  end

  assign in_tready  = !busy_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  a_count_max : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= PW'(DEPTH))
    else $error("length above depth");

  a_ins_grows : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + PW'(1))
    else $error("insert did not grow the list");

  a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_data_r[EW + 2 * PW + 2] == (out_data_r[EW + PW + 2 +: PW] == '0)))
    else $error("empty flag disagrees with length");

  a_err_no_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (out_data_r[EW + PW +: 2] != ST_DONE) |-> out_data_r[EW-1:0] == '0)
    else $error("value returned on a rejected request");

  a_hold_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !fin |=> busy_r && (count_r == $past(count_r)))
    else $error("list changed while a request was in flight");

endmodule

// File: sv/oal_cell.sv
module oal_cell #(
  parameter int IDX = 0,
  parameter int EW  = 32,
  parameter int PW  = 9
) (
  input  logic                clk,
  input  oal_pkg::cell_ctl_t  ctl,
  input  logic [PW-1:0]       pos_idx,
  input  logic [PW-1:0]       count,
  input  logic [EW-1:0]       item_value,
  input  logic [EW-1:0]       left_val,
  input  logic [EW-1:0]       right_val,
  output logic [EW-1:0]       slot_val,
  output logic                leaf_hit
);
  import oal_pkg::*;

  localparam logic [PW-1:0] ME = PW'(IDX);

  logic [EW-1:0] slot_r;
  logic [EW-1:0] slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.ins) begin
      if (ME == pos_idx) begin
        slot_nxt = item_value;
      end else if (ME > pos_idx) begin
        slot_nxt = left_val;
      end
    end else if (ctl.del && (ME >= pos_idx)) begin
      slot_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_val = slot_r;
  assign leaf_hit = ctl.loc ? ((ME < count) && (slot_r == item_value)) : (ME == pos_idx);

endmodule

// File: sv/oal_tree.sv
module oal_tree #(
  parameter int DEPTH = 256,
  parameter int EW    = 32
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [DEPTH-1:0]          leaf_hit,
  input  logic [EW-1:0]             leaf_val [DEPTH],
  output logic                      root_hit,
  output logic [$clog2(DEPTH)-1:0]  root_idx,
  output logic [EW-1:0]             root_val
);

  localparam int IW = $clog2(DEPTH);
  localparam int P  = 1 << IW;

  logic          lf_hit_r [P];
  logic [EW-1:0] lf_val_r [P];
  logic          nd_hit_r [P-1];
  logic [IW-1:0] nd_idx_r [P-1];
  logic [EW-1:0] nd_val_r [P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < DEPTH) begin : g_real
      always_ff @(posedge clk) begin
        if (load) begin
          lf_hit_r[i] <= leaf_hit[i];
          lf_val_r[i] <= leaf_val[i];
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        lf_hit_r[i] <= 1'b0;
        lf_val_r[i] <= '0;
      end
    end
  end

  for (genvar n = 0; n < P - 1; n++) begin : g_node
    localparam int C0 = 2 * n + 1;
    localparam int C1 = 2 * n + 2;
    if (C0 >= P - 1) begin : g_over_leaves
      localparam int L0 = C0 - (P - 1);
      localparam int L1 = C1 - (P - 1);
      always_ff @(posedge clk) begin
        nd_hit_r[n] <= lf_hit_r[L0] | lf_hit_r[L1];
        if (lf_hit_r[L0]) begin
          nd_idx_r[n] <= IW'(L0);
          nd_val_r[n] <= lf_val_r[L0];
        end else begin
          nd_idx_r[n] <= IW'(L1);
          nd_val_r[n] <= lf_val_r[L1];
        end
      end
    end else begin : g_over_nodes
      always_ff @(posedge clk) begin
        nd_hit_r[n] <= nd_hit_r[C0] | nd_hit_r[C1];
        if (nd_hit_r[C0]) begin
          nd_idx_r[n] <= nd_idx_r[C0];
          nd_val_r[n] <= nd_val_r[C0];
        end else begin
          nd_idx_r[n] <= nd_idx_r[C1];
          nd_val_r[n] <= nd_val_r[C1];
        end
      end
    end
  end

  assign root_hit = nd_hit_r[0];
  assign root_idx = nd_idx_r[0];
  assign root_val = nd_val_r[0];

endmodule

// File: test/tb_ordered_array_list.sv
`timescale 1ns / 1ps

module tb_ordered_array_list;
  import oal_pkg::*;

  localparam int LIST_DEPTH = 256;
  localparam int RANDOM_ITEMS = 1500;
  localparam int TAIL_ITEMS = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [31:0] item_value;
    logic [8:0]  position;
    mode_t       mode;
  } req_t;

  typedef struct packed {
    logic        is_empty;
    logic [8:0]  length;
    status_t     status;
    logic [8:0]  found_position;
    logic [31:0] read_value;
  } res_t;

  typedef struct {
    bit   hold;
    req_t req;
  } item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  ordered_array_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  item_t       req_q[$];
  res_t        answers_q[$];
  logic [31:0] list_mem[LIST_DEPTH];
  int          list_len;
  logic [31:0] value_pool[8];
  int          gen_len;
  int          rand_cnt;

  bit          in_fire;
  bit          lazy;
  int          gap_left;
  int          stall_left;
  int          idle_cycles;
  int          errors;
  int          n_results;
  int          n_insert, n_delete, n_full, n_range, n_hit, n_miss, n_get, peak_len;

  bit          nxt_valid;
  req_t        nxt_req;
  item_t       nxt_item;
  res_t        got;
  res_t        want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predicted list: insert/delete shift, locate/get read below the length
  function automatic res_t list_apply(req_t r);
    res_t o;
    int   k;
    o = '0;
    case (r.mode)
      MODE_INSERT: begin
        if (r.position == 0 || r.position > list_len + 1) begin
          o.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (k = list_len; k >= r.position; k--) list_mem[k] = list_mem[k - 1];
          list_mem[r.position - 1] = r.item_value;
          list_len++;
          n_insert++;
        end
      end
      MODE_DELETE: begin
        if (r.position == 0 || r.position > list_len) begin
          o.status = ST_RANGE;
        end else begin
          o.read_value = list_mem[r.position - 1];
          for (k = r.position; k < list_len; k++) list_mem[k - 1] = list_mem[k];
          list_len--;
          n_delete++;
        end
      end
      MODE_LOCATE: begin
        for (k = 0; k < list_len && o.found_position == 0; k++) begin
          if (list_mem[k] == r.item_value) o.found_position = 9'(k + 1);
        end
        if (o.found_position != 0) n_hit++;
        else n_miss++;
      end
      default: begin
        if (r.position == 0 || r.position > list_len) begin
          o.status = ST_RANGE;
        end else begin
          o.read_value = list_mem[r.position - 1];
          n_get++;
        end
      end
    endcase
    if (o.status == ST_RANGE) n_range++;
    if (o.status == ST_FULL) n_full++;
    if (list_len > peak_len) peak_len = list_len;
    o.length = 9'(list_len);
    o.is_empty = (list_len == 0);
    return o;
  endfunction

  task automatic add_req(mode_t m, logic [8:0] p, logic [31:0] v, bit h);
    item_t it;
    it.hold = h;
    it.req.mode = m;
    it.req.position = p;
    it.req.item_value = v;
    req_q.push_back(it);
    if (m == MODE_INSERT && p != 0 && p <= gen_len + 1 && gen_len < LIST_DEPTH) gen_len++;
    if (m == MODE_DELETE && p != 0 && p <= gen_len) gen_len--;
  endtask

  function automatic logic [31:0] pick_value(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [8:0] pick_pos(mode_t m, bit bad);
    int hi;
    if (m == MODE_LOCATE) return 9'($urandom_range(0, LIST_DEPTH));
    hi = (m == MODE_INSERT) ? gen_len + 1 : gen_len;
    if (hi > LIST_DEPTH) hi = LIST_DEPTH;
    if (bad || hi == 0) begin
      if ($urandom_range(0, 1) == 0 || hi + 1 > LIST_DEPTH) return 9'd0;
      return 9'($urandom_range(hi + 1, LIST_DEPTH));
    end
    return 9'($urandom_range(1, hi));
  endfunction

  task automatic add_random(int ins_w, int del_w, int loc_w, bit h);
    int    r;
    mode_t m;
    r = $urandom_range(0, 99);
    if (r < ins_w) m = MODE_INSERT;
    else if (r < ins_w + del_w) m = MODE_DELETE;
    else if (r < ins_w + del_w + loc_w) m = MODE_LOCATE;
    else m = MODE_GET;
    add_req(m, pick_pos(m, $urandom_range(0, 99) < 8),
            pick_value(m == MODE_LOCATE ? 70 : 40), h);
    rand_cnt++;
  endtask

  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    end
  endtask

  // input beat driver
  always @(negedge clk) begin
    nxt_valid = in_tvalid;
    nxt_req = req_t'(in_tdata[42:0]);
    if (in_fire) begin
      nxt_valid = 1'b0;
      lazy = ($urandom_range(0, 3) == 0);
    end
    if (rst_n && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0 && !(req_q[0].hold && answers_q.size() != 0)) begin
        if (req_q.size() >= TAIL_ITEMS && $urandom_range(0, 99) < (lazy ? 75 : 15)) begin
          gap_left = $urandom_range(0, 2);
        end else begin
          nxt_item = req_q.pop_front();
          nxt_req = nxt_item.req;
          nxt_valid = 1'b1;
          lazy = 1'b0;
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata <= {5'b0, nxt_req};
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (req_q.size() >= TAIL_ITEMS && $urandom_range(0, 99) < 20) begin
      stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // beat monitor and checker
  always @(posedge clk) begin
    in_fire = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_fire = 1'b1;
        answers_q.push_back(list_apply(req_t'(in_tdata[42:0])));
      end
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[52:0]);
        n_results++;
        if (answers_q.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with none expected, expected none, actual %0h",
                   $time, out_tdata);
        end else begin
          want = answers_q.pop_front();
          check_field("read_value", want.read_value, got.read_value);
          check_field("found_position", want.found_position, got.found_position);
          check_field("status", want.status, got.status);
          check_field("length", want.length, got.length);
          check_field("is_empty", want.is_empty, got.is_empty);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("tb_ordered_array_list NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    list_len = 0;
    gen_len = 0;
    value_pool[0] = 32'h0;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h0000_0001;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // directed: empty list, ends, middle, rejects, drain to empty
    add_req(MODE_GET,    9'd1,   32'h0,         1'b0);
    add_req(MODE_DELETE, 9'd1,   32'h0,         1'b0);
    add_req(MODE_LOCATE, 9'd0,   32'h0,         1'b0);
    add_req(MODE_INSERT, 9'd0,   32'h1234_5678, 1'b0);
    add_req(MODE_INSERT, 9'd2,   32'h1234_5678, 1'b0);
    add_req(MODE_INSERT, 9'd1,   32'h0,         1'b0);
    add_req(MODE_INSERT, 9'd1,   32'hFFFF_FFFF, 1'b0);
    add_req(MODE_INSERT, 9'd3,   32'hA5A5_A5A5, 1'b0);
    add_req(MODE_INSERT, 9'd2,   32'h5A5A_5A5A, 1'b0);
    add_req(MODE_LOCATE, 9'd256, 32'hFFFF_FFFF, 1'b0);
    add_req(MODE_LOCATE, 9'd0,   32'h0,         1'b0);
    add_req(MODE_LOCATE, 9'd1,   32'h1234_5678, 1'b0);
    add_req(MODE_GET,    9'd4,   32'h0,         1'b0);
    add_req(MODE_GET,    9'd5,   32'h0,         1'b0);
    add_req(MODE_GET,    9'd0,   32'h0,         1'b0);
    add_req(MODE_DELETE, 9'd0,   32'h0,         1'b0);
    add_req(MODE_DELETE, 9'd5,   32'h0,         1'b0);
    add_req(MODE_DELETE, 9'd2,   32'h0,         1'b0);
    add_req(MODE_DELETE, 9'd3,   32'h0,         1'b0);
    add_req(MODE_DELETE, 9'd1,   32'h0,         1'b0);
    add_req(MODE_GET,    9'd1,   32'h0,         1'b0);
    add_req(MODE_DELETE, 9'd1,   32'h0,         1'b0);
    add_req(MODE_INSERT, 9'd256, 32'hFFFF_FFFF, 1'b0);

    // random: fill to full, churn, drain to empty, churn
    while (rand_cnt < RANDOM_ITEMS) begin
      add_random(70, 10, 10, 1'b1);
      while (gen_len < LIST_DEPTH && rand_cnt < RANDOM_ITEMS) add_random(70, 10, 10, 1'b0);
      if (gen_len == LIST_DEPTH) begin
        repeat (3) add_req(MODE_INSERT, 9'($urandom_range(1, LIST_DEPTH)), $urandom, 1'b0);
        add_req(MODE_GET, 9'd256, 32'h0, 1'b0);
        add_req(MODE_LOCATE, 9'd0, pick_value(80), 1'b0);
      end
      repeat (150) if (rand_cnt < RANDOM_ITEMS) add_random(25, 25, 25, 1'b0);
      if (rand_cnt < RANDOM_ITEMS) add_random(10, 70, 10, 1'b1);
      while (gen_len > 0 && rand_cnt < RANDOM_ITEMS) add_random(10, 70, 10, 1'b0);
      if (gen_len == 0) begin
        add_req(MODE_DELETE, 9'd1, 32'h0, 1'b0);
        add_req(MODE_GET, 9'd256, 32'h0, 1'b0);
        add_req(MODE_LOCATE, 9'd0, pick_value(80), 1'b0);
      end
      repeat (100) if (rand_cnt < RANDOM_ITEMS) add_random(25, 25, 25, 1'b0);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_tvalid || answers_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answers_q.size() != 0) errors++;

    $display("covered %0d results: %0d inserts, %0d deletes, %0d gets, %0d full, %0d range",
             n_results, n_insert, n_delete, n_get, n_full, n_range);
    $display("locates found %0d / absent %0d, peak length %0d, %0d mismatches",
             n_hit, n_miss, peak_len, errors);
    if (errors == 0) begin
      $display("tb_ordered_array_list OK");
    end else begin
      $display("tb_ordered_array_list NOT OK");
    end
    $finish;
  end

endmodule
